// ===== rtl/rbpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpd_pkg
// Shared types and constants for the redundant byte page decoder.
// ----------------------------------------------------------------------------
package rbpd_pkg;

    localparam int BYTES_PER_WORD = 8;
    localparam int REC_WORDS_MAX  = 3;                   // reach of the 2-bit word count
    localparam int REC_BYTES      = BYTES_PER_WORD * REC_WORDS_MAX;
    localparam int HDR_COUNT_END  = 4;                   // bytes 0..3: record count
    localparam int HDR_END        = 8;                   // bytes 4..7: skipped

    localparam logic [7:0] SKIP_FORMAT = 8'h02;

    typedef logic [REC_BYTES-1:0] t_pos_mask;

    typedef struct packed {
        logic [63:0] word_zero;
        logic [63:0] word_one;
        logic [63:0] word_two;
        logic        last_in_page;
        logic        overrun;
    } t_result;

endpackage

// ===== rtl/rbpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpd_page_if / rbpd_rec_if
// Valid/ready channels for page bytes in and rebuilt records out.
// ----------------------------------------------------------------------------
interface rbpd_page_if;
    logic       valid;
    logic       ready;
    logic [7:0] page_byte;
    logic       page_start;

    modport source (output valid, output page_byte, output page_start, input ready);
    modport sink   (input valid, input page_byte, input page_start, output ready);
endinterface

interface rbpd_rec_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_zero;
    logic [63:0] word_one;
    logic [63:0] word_two;
    logic        last_in_page;
    logic        overrun;

    modport source (output valid, output word_zero, output word_one, output word_two,
                    output last_in_page, output overrun, input ready);
    modport sink   (input valid, input word_zero, input word_one, input word_two,
                    input last_in_page, input overrun, output ready);
endinterface

// ===== rtl/rbpd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpd_core
// Page parse state and record assembly; one byte per step.
// ----------------------------------------------------------------------------
module rbpd_core
    import rbpd_pkg::*;
#(
    parameter int PAGE_BYTES       = 4096,
    parameter int MAX_RECORD_WORDS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic [1:0] i_record_words,
    output logic       o_has_res,
    output t_result    o_res
);

    localparam int OffW = $clog2(PAGE_BYTES);
    localparam int MaxW = (MAX_RECORD_WORDS < REC_WORDS_MAX) ? MAX_RECORD_WORDS
                                                             : REC_WORDS_MAX;

    logic [OffW-1:0] r_off, n_off;
    logic [31:0]     r_total, n_total;
    logic [31:0]     r_emitted, n_emitted;
    t_pos_mask       r_mask, n_mask;
    t_pos_mask       r_shared_left, n_shared_left;
    t_pos_mask       r_uniq_left, n_uniq_left;
    logic [1:0]      r_pw, n_pw;
    logic            r_skipped, n_skipped;
    logic [7:0]      r_asm [REC_BYTES];
    logic [7:0]      n_asm [REC_BYTES];

    logic [OffW-1:0] off;
    logic            last_byte;
    logic [1:0]      mask_idx;
    t_pos_mask       len_mask;
    t_pos_mask       mask_new;
    t_pos_mask       uniq_full;
    t_pos_mask       sel;
    t_pos_mask       uniq_rem;
    logic            done;
    logic            fin;
    logic [63:0]     words [REC_WORDS_MAX];

    function automatic t_pos_mask f_len_mask(input logic [1:0] pw);
        t_pos_mask m;
        m = '0;
        for (int k = 0; k < REC_BYTES; k++) begin
            if (k < BYTES_PER_WORD * int'(pw)) m[k] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [1:0] f_clamp(input logic [1:0] rw);
        logic [1:0] w;
        if (rw == 2'd0) begin
            w = 2'd1;
        end else if (int'(rw) > MaxW) begin
            w = 2'(MaxW);
        end else begin
            w = rw;
        end
        return w;
    endfunction

    always_comb begin
        off       = i_start ? '0 : r_off;
        last_byte = (off == OffW'(PAGE_BYTES - 1));
        mask_idx  = 2'(off - OffW'(HDR_END));
        len_mask  = f_len_mask(r_pw);
        uniq_full = ~r_mask & len_mask;
        mask_new  = r_mask | (t_pos_mask'(i_byte) << {mask_idx, 3'b000});
        sel       = '0;
        uniq_rem  = '0;
        done      = 1'b0;
        fin       = 1'b0;

        n_total       = r_total;
        n_emitted     = r_emitted;
        n_mask        = r_mask;
        n_shared_left = r_shared_left;
        n_uniq_left   = r_uniq_left;
        n_pw          = r_pw;
        n_skipped     = r_skipped;
        o_has_res     = 1'b0;
        o_res         = '0;

        if (off == '0) begin
            n_total       = {24'd0, i_byte};
            n_emitted     = '0;
            n_mask        = '0;
            n_shared_left = '0;
            n_uniq_left   = '0;
            n_skipped     = (i_byte == SKIP_FORMAT);
            n_pw          = f_clamp(i_record_words);
        end else if (!r_skipped) begin
            if (off < OffW'(HDR_COUNT_END)) begin
                n_total = r_total | ({24'd0, i_byte} << {off[1:0], 3'b000});
            end else if (off < OffW'(HDR_END)) begin
                n_total = r_total;
            end else if (off < OffW'(HDR_END) + OffW'(r_pw)) begin
                n_mask = mask_new;
                if (off == OffW'(HDR_END) + OffW'(r_pw) - OffW'(1)) begin
                    n_shared_left = mask_new & len_mask;
                    n_uniq_left   = ~mask_new & len_mask;
                end
            end else if (r_shared_left != '0) begin
                // shared values arrive in position order: fill lowest open slot
                sel           = r_shared_left & (~r_shared_left + t_pos_mask'(1));
                n_shared_left = r_shared_left & ~sel;
            end else if (r_emitted < r_total) begin
                if (uniq_full == '0) begin
                    done = 1'b1;
                end else begin
                    sel      = r_uniq_left & (~r_uniq_left + t_pos_mask'(1));
                    uniq_rem = r_uniq_left & ~sel;
                    if (uniq_rem == '0) begin
                        done        = 1'b1;
                        n_uniq_left = uniq_full;
                    end else begin
                        n_uniq_left = uniq_rem;
                    end
                end
                if (done) begin
                    n_emitted = r_emitted + 32'd1;
                    fin       = (n_emitted == r_total);
                    o_has_res = 1'b1;
                end else if (last_byte) begin
                    o_has_res = 1'b1;
                end
            end
        end

        for (int k = 0; k < REC_BYTES; k++) begin
            n_asm[k] = sel[k] ? i_byte : r_asm[k];
        end

        for (int w = 0; w < REC_WORDS_MAX; w++) begin
            words[w] = '0;
            for (int j = 0; j < BYTES_PER_WORD; j++) begin
                words[w][8*j +: 8] = n_asm[w*BYTES_PER_WORD + j];
            end
            if (!done || w >= int'(r_pw)) words[w] = '0;
        end

        if (o_has_res) begin
            o_res.word_zero    = words[0];
            o_res.word_one     = words[1];
            o_res.word_two     = words[2];
            o_res.last_in_page = fin || last_byte;
            o_res.overrun      = !fin && last_byte;
        end

        n_off = last_byte ? '0 : off + OffW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off         <= '0;
            r_total       <= '0;
            r_emitted     <= '0;
            r_mask        <= '0;
            r_shared_left <= '0;
            r_uniq_left   <= '0;
            r_pw          <= 2'd1;
            r_skipped     <= 1'b0;
        end else if (i_step) begin
            r_off         <= n_off;
            r_total       <= n_total;
            r_emitted     <= n_emitted;
            r_mask        <= n_mask;
            r_shared_left <= n_shared_left;
            r_uniq_left   <= n_uniq_left;
            r_pw          <= n_pw;
            r_skipped     <= n_skipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int k = 0; k < REC_BYTES; k++) begin
                r_asm[k] <= n_asm[k];
            end
        end
    end

endmodule

// ===== rtl/redundant_byte_page_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_byte_page_decoder
// Rebuilds records of a leaf page with shared bytes from a byte stream.
// ----------------------------------------------------------------------------
// Takes one page byte per clock, except when a new result meets a record
// still held in the output register. A beat is captured in an input
// register; when it is processed it is parsed and merged into the record
// buffer, and a finished record is loaded into the output register in the same cycle. The output
// register frees the input side while a record waits to be taken; the input
// stalls only when a byte would produce a record or an overrun result while
// the previous one is still held. The word count is sampled on the first byte of each page.
// Pages whose first byte is 0x02 produce no output.
module redundant_byte_page_decoder
    import rbpd_pkg::*;
#(
    parameter int PAGE_BYTES       = 4096,
    parameter int MAX_RECORD_WORDS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    rbpd_page_if.sink  i_page,
    rbpd_rec_if.source o_rec
);

    logic [1:0] r_rw;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_vld;
    t_result    r_out;

    logic       proc_fire;
    logic       has_res;
    t_result    res;

    rbpd_core #(
        .PAGE_BYTES       (PAGE_BYTES),
        .MAX_RECORD_WORDS (MAX_RECORD_WORDS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (proc_fire),
        .i_byte         (r_in_byte),
        .i_start        (r_in_start),
        .i_record_words (r_rw),
        .o_has_res      (has_res),
        .o_res          (res)
    );

    assign proc_fire    = r_in_vld && (!has_res || !r_out_vld || o_rec.ready);
    assign i_page.ready = !r_in_vld || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw <= 2'd1;
        end else if (i_cfg_wr_en) begin
            r_rw <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_page.ready) begin
            r_in_vld <= i_page.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_page.ready && i_page.valid) begin
            r_in_byte  <= i_page.page_byte;
            r_in_start <= i_page.page_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_fire && has_res) begin
            r_out_vld <= 1'b1;
        end else if (o_rec.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && has_res) begin
            r_out <= res;
        end
    end

    assign o_rec.valid        = r_out_vld;
    assign o_rec.word_zero    = r_out.word_zero;
    assign o_rec.word_one     = r_out.word_one;
    assign o_rec.word_two     = r_out.word_two;
    assign o_rec.last_in_page = r_out.last_in_page;
    assign o_rec.overrun      = r_out.overrun;

endmodule
